### rtl/core/ccae_pkg.sv
`default_nettype none

package ccae_pkg;

    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_SEMI  = 8'h3B;
    localparam logic [7:0] CHR_N     = 8'h4E;
    localparam logic [7:0] CHR_S     = 8'h53;
    localparam logic [7:0] CHR_X     = 8'h58;
    localparam logic [7:0] CHR_Y     = 8'h59;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_A     = 8'h41;

    localparam logic [3:0] STD_MAX_BYTES = 4'd7;
    localparam logic [3:0] EXT_MAX_BYTES = 4'd8;

    localparam logic [2:0] STD_HDR_LAST_NIB = 3'd3;
    localparam logic [2:0] EXT_HDR_LAST_NIB = 3'd7;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0]  kind_char;
        logic [2:0]  hdr_last_nib;
        logic [31:0] hdr;
        logic [3:0]  body_len;
        logic [63:0] body;
    } desc_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10) begin
            hex_char = CHR_ZERO + wide;
        end else begin
            hex_char = CHR_A + wide - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/ccae_front.sv
`default_nettype none

module ccae_front
    import ccae_pkg::*;
(
    input  wire logic [1:0]  frame_kind,
    input  wire logic [7:0]  sid_high,
    input  wire logic [7:0]  sid_low,
    input  wire logic [7:0]  eid_high,
    input  wire logic [7:0]  eid_low,
    input  wire logic [7:0]  opcode,
    input  wire logic [3:0]  data_count,
    input  wire logic [63:0] payload,
    output desc_t            desc
);

    logic       is_ext;
    logic [3:0] std_cnt;
    logic [3:0] ext_cnt;

    assign is_ext  = frame_kind[1];
    assign std_cnt = (data_count > STD_MAX_BYTES) ? STD_MAX_BYTES : data_count;
    assign ext_cnt = (data_count > EXT_MAX_BYTES) ? EXT_MAX_BYTES : data_count;

    // A standard frame's "0000" is sent as hex of a zero header, and its opcode
    // leads the data bytes, so both kinds share one character sequence.
    always_comb begin
        if (is_ext) begin
            desc.kind_char    = CHR_X;
            desc.hdr_last_nib = EXT_HDR_LAST_NIB;
            desc.hdr          = {sid_high, sid_low, eid_high, eid_low};
            desc.body_len     = ext_cnt;
            desc.body         = payload;
        end else begin
            desc.kind_char    = frame_kind[0] ? CHR_Y : CHR_S;
            desc.hdr_last_nib = STD_HDR_LAST_NIB;
            desc.hdr          = 32'h0;
            desc.body_len     = std_cnt + 4'd1;
            desc.body         = {payload[55:0], opcode};
        end
    end

endmodule

`default_nettype wire

### rtl/core/ccae_queue.sv
`default_nettype none

module ccae_queue
    import ccae_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  wire desc_t wr_data,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output desc_t      rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ccae_back.sv
`default_nettype none

module ccae_back
    import ccae_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    output logic            q_ready,
    input  wire desc_t      q_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_text_char,
    output logic            m_last_char
);

    localparam logic [2:0] PH_COLON = 3'd0;
    localparam logic [2:0] PH_KIND  = 3'd1;
    localparam logic [2:0] PH_HDR   = 3'd2;
    localparam logic [2:0] PH_N     = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;
    localparam logic [2:0] PH_END   = 3'd5;

    logic        busy_reg,      busy_next;
    logic [2:0]  phase_reg,     phase_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg,  out_char_next;
    logic        out_last_reg,  out_last_next;
    logic [7:0]  kind_char_reg, kind_char_next;
    logic [2:0]  nib_cnt_reg,   nib_cnt_next;
    logic [31:0] hdr_reg,       hdr_next;
    logic [3:0]  body_left_reg, body_left_next;
    logic [63:0] body_reg,      body_next;
    logic        nib_hi_reg,    nib_hi_next;

    logic       advance;
    logic       finishing;
    logic       load;
    logic [7:0] cur_char;

    assign advance     = busy_reg && (!out_valid_reg || m_ready);
    assign finishing   = advance && (phase_reg == PH_END);
    assign load        = q_valid && (!busy_reg || finishing);
    assign q_ready     = load;
    assign m_valid     = out_valid_reg;
    assign m_text_char = out_char_reg;
    assign m_last_char = out_last_reg;

    always_comb begin
        case (phase_reg)
            PH_COLON: cur_char = CHR_COLON;
            PH_KIND:  cur_char = kind_char_reg;
            PH_HDR:   cur_char = hex_char(hdr_reg[31:28]);
            PH_N:     cur_char = CHR_N;
            PH_BODY:  cur_char = hex_char(nib_hi_reg ? body_reg[7:4] : body_reg[3:0]);
            default:  cur_char = CHR_SEMI;
        endcase
    end

    always_comb begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        kind_char_next = kind_char_reg;
        nib_cnt_next   = nib_cnt_reg;
        hdr_next       = hdr_reg;
        body_left_next = body_left_reg;
        body_next      = body_reg;
        nib_hi_next    = nib_hi_reg;

        if (advance) begin
            out_valid_next = 1'b1;
            out_char_next  = cur_char;
            out_last_next  = (phase_reg == PH_END);
            case (phase_reg)
                PH_COLON: begin
                    phase_next = PH_KIND;
                end
                PH_KIND: begin
                    phase_next = PH_HDR;
                end
                PH_HDR: begin
                    hdr_next = {hdr_reg[27:0], 4'h0};
                    if (nib_cnt_reg == 3'd0) begin
                        phase_next = PH_N;
                    end else begin
                        nib_cnt_next = nib_cnt_reg - 3'd1;
                    end
                end
                PH_N: begin
                    nib_hi_next = 1'b1;
                    phase_next  = (body_left_reg == 4'd0) ? PH_END : PH_BODY;
                end
                PH_BODY: begin
                    if (nib_hi_reg) begin
                        nib_hi_next = 1'b0;
                    end else begin
                        nib_hi_next    = 1'b1;
                        body_next      = {8'h00, body_reg[63:8]};
                        body_left_next = body_left_reg - 4'd1;
                        if (body_left_reg == 4'd1) begin
                            phase_next = PH_END;
                        end
                    end
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end else if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (load) begin
            busy_next      = 1'b1;
            phase_next     = PH_COLON;
            kind_char_next = q_data.kind_char;
            nib_cnt_next   = q_data.hdr_last_nib;
            hdr_next       = q_data.hdr;
            body_left_next = q_data.body_len;
            body_next      = q_data.body;
            nib_hi_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_COLON;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        kind_char_reg <= kind_char_next;
        nib_cnt_reg   <= nib_cnt_next;
        hdr_reg       <= hdr_next;
        body_left_reg <= body_left_next;
        body_reg      <= body_next;
        nib_hi_reg    <= nib_hi_next;
    end

    a_last_is_semi: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_last_reg |-> out_char_reg == CHR_SEMI)
        else $error("last character is not a semicolon");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> !busy_reg || finishing)
        else $error("descriptor loaded while a frame is still in progress");

    a_body_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (phase_reg == PH_BODY) |-> body_left_reg != 4'd0 && body_left_reg <= 4'd8)
        else $error("data byte count out of range");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> busy_reg == $past(busy_reg) || $past(load))
        else $error("sequencer changed while output was stalled");

endmodule

`default_nettype wire

### rtl/core/can_frame_ascii_encoder_unit.sv
`default_nettype none

// Channel  Direction  Handshake           Fields
// s_       in         s_valid / s_ready   frame_kind sid_high sid_low eid_high eid_low
//                                         opcode data_count payload
// m_       out        m_valid / m_ready   text_char last_char
//
// One character leaves per cycle while m_ready is high; a frame is 10 to 24 characters
// (standard) or 12 to 28 characters (extended), set by the back end's character sequencer.
// Frames follow each other without a gap; a two-entry descriptor queue lets new
// transactions be taken while the current frame is still being sent.
// Reset is synchronous and active low; it empties the queue and the sequencer.
// With m_ready low the pending character holds and input stalls once the queue fills.

module can_frame_ascii_encoder_unit
    import ccae_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_frame_kind,
    input  wire logic [7:0]  s_sid_high,
    input  wire logic [7:0]  s_sid_low,
    input  wire logic [7:0]  s_eid_high,
    input  wire logic [7:0]  s_eid_low,
    input  wire logic [7:0]  s_opcode,
    input  wire logic [3:0]  s_data_count,
    input  wire logic [63:0] s_payload,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_text_char,
    output logic             m_last_char
);

    desc_t front_desc;
    desc_t q_desc;
    logic  q_valid;
    logic  q_ready;

    ccae_front u_front (
        .frame_kind (s_frame_kind),
        .sid_high   (s_sid_high),
        .sid_low    (s_sid_low),
        .eid_high   (s_eid_high),
        .eid_low    (s_eid_low),
        .opcode     (s_opcode),
        .data_count (s_data_count),
        .payload    (s_payload),
        .desc       (front_desc)
    );

    ccae_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (front_desc),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_desc)
    );

    ccae_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_desc),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last_char (m_last_char)
    );

endmodule

`default_nettype wire

### sim/can_frame_ascii_encoder_unit_tb.sv
module can_frame_ascii_encoder_unit_tb;
    import ccae_pkg::*;

    localparam logic [1:0] KIND_STD      = 2'd0;
    localparam logic [1:0] KIND_STD_FLAG = 2'd1;
    localparam logic [1:0] KIND_EXT      = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    localparam int RANDOM_FRAMES  = 100;
    localparam int CALM_TAIL      = 20;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 40;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int SETTLE_CYCLES  = 60;

    typedef struct packed {
        logic        drain_first;
        logic [1:0]  kind;
        logic [7:0]  sid_high;
        logic [7:0]  sid_low;
        logic [7:0]  eid_high;
        logic [7:0]  eid_low;
        logic [7:0]  opcode;
        logic [3:0]  count;
        logic [63:0] payload;
    } can_frame_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } ascii_char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_frame_kind = '0;
    logic [7:0]  s_sid_high = '0;
    logic [7:0]  s_sid_low = '0;
    logic [7:0]  s_eid_high = '0;
    logic [7:0]  s_eid_low = '0;
    logic [7:0]  s_opcode = '0;
    logic [3:0]  s_data_count = '0;
    logic [63:0] s_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_text_char;
    logic        m_last_char;

    can_frame_t  pending_frames[$];
    ascii_char_t expected_chars[$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  frames_taken = 0;
    bit  frame_taken = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;

    can_frame_ascii_encoder_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_frame_kind (s_frame_kind),
        .s_sid_high   (s_sid_high),
        .s_sid_low    (s_sid_low),
        .s_eid_high   (s_eid_high),
        .s_eid_low    (s_eid_low),
        .s_opcode     (s_opcode),
        .s_data_count (s_data_count),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_text_char  (m_text_char),
        .m_last_char  (m_last_char)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CHR_ZERO + {4'h0, nib};
        end
        return CHR_A + {4'h0, nib} - 8'd10;
    endfunction

    function automatic void push_char(input logic [7:0] c, input logic last);
        ascii_char_t entry;
        entry.text_char = c;
        entry.last_char = last;
        expected_chars.push_back(entry);
    endfunction

    function automatic void push_hex(input logic [7:0] b);
        push_char(nibble_ascii(b[7:4]), 1'b0);
        push_char(nibble_ascii(b[3:0]), 1'b0);
    endfunction

    function automatic void encode_frame(input logic [1:0] kind, input logic [7:0] sid_high,
                                         input logic [7:0] sid_low, input logic [7:0] eid_high,
                                         input logic [7:0] eid_low, input logic [7:0] opcode,
                                         input logic [3:0] count, input logic [63:0] payload);
        logic [3:0] n_bytes;
        push_char(CHR_COLON, 1'b0);
        if (kind[1]) begin
            n_bytes = (count > EXT_MAX_BYTES) ? EXT_MAX_BYTES : count;
            push_char(CHR_X, 1'b0);
            push_hex(sid_high);
            push_hex(sid_low);
            push_hex(eid_high);
            push_hex(eid_low);
            push_char(CHR_N, 1'b0);
        end else begin
            n_bytes = (count > STD_MAX_BYTES) ? STD_MAX_BYTES : count;
            push_char(kind[0] ? CHR_Y : CHR_S, 1'b0);
            repeat (4) push_char(CHR_ZERO, 1'b0);
            push_char(CHR_N, 1'b0);
            push_hex(opcode);
        end
        for (int i = 0; i < int'(n_bytes); i++) begin
            push_hex(payload[8*i +: 8]);
        end
        push_char(CHR_SEMI, 1'b1);
    endfunction

    function automatic can_frame_t make_frame(input logic [1:0] kind, input logic [31:0] hdr,
                                              input logic [7:0] opcode, input logic [3:0] count,
                                              input logic [63:0] payload);
        can_frame_t f;
        f.drain_first = 1'b0;
        f.kind = kind;
        {f.sid_high, f.sid_low, f.eid_high, f.eid_low} = hdr;
        f.opcode = opcode;
        f.count = count;
        f.payload = payload;
        return f;
    endfunction

    function automatic can_frame_t random_frame();
        can_frame_t f;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            f.kind = KIND_STD;
        end else if (pick < 6) begin
            f.kind = KIND_STD_FLAG;
        end else if (pick < 9) begin
            f.kind = KIND_EXT;
        end else begin
            f.kind = KIND_UNUSED;
        end
        f.drain_first = 1'b0;
        f.sid_high = 8'($urandom);
        f.sid_low = 8'($urandom);
        f.eid_high = 8'($urandom);
        f.eid_low = 8'($urandom);
        f.opcode = 8'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            f.count = 4'($urandom_range(9, 15));
        end else begin
            f.count = 4'($urandom_range(0, 8));
        end
        f.payload = {$urandom, $urandom};
        return f;
    endfunction

    // Input and output transactions are both taken at the rising edge.
    always @(posedge aclk) begin
        ascii_char_t exp_char;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Verification failed");
            $finish;
        end
        if (aresetn) begin
            if (s_valid && s_ready) begin
                encode_frame(s_frame_kind, s_sid_high, s_sid_low, s_eid_high, s_eid_low,
                             s_opcode, s_data_count, s_payload);
                frames_taken = frames_taken + 1;
                frame_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character, expected none, actual %h last %b",
                             $time, m_text_char, m_last_char);
                    error_count++;
                end else begin
                    exp_char = expected_chars.pop_front();
                    if (m_text_char !== exp_char.text_char) begin
                        $display("%0t: text_char mismatch, expected %h, actual %h",
                                 $time, exp_char.text_char, m_text_char);
                        error_count++;
                    end
                    if (m_last_char !== exp_char.last_char) begin
                        $display("%0t: last_char mismatch, expected %b, actual %b",
                                 $time, exp_char.last_char, m_last_char);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        can_frame_t f;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || frame_taken) begin
            frame_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_frames.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending_frames[0].drain_first && expected_chars.size() != 0) begin
                s_valid <= 1'b0;
            end else if (pending_frames.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 9);
                s_valid <= 1'b0;
            end else begin
                f = pending_frames.pop_front();
                s_valid <= 1'b1;
                s_frame_kind <= f.kind;
                s_sid_high <= f.sid_high;
                s_sid_low <= f.sid_low;
                s_eid_high <= f.eid_high;
                s_eid_low <= f.eid_low;
                s_opcode <= f.opcode;
                s_data_count <= f.count;
                s_payload <= f.payload;
            end
        end
    end

    // The long hold lets the descriptor queue fill so that s_ready drops.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && frames_taken >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else if (pending_frames.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        can_frame_t f;
        pending_frames.push_back(make_frame(KIND_STD, 32'h0, 8'h00, 4'd0, 64'h0));
        pending_frames.push_back(make_frame(KIND_STD, 32'hFFFF_FFFF, 8'hFF, 4'd7,
                                            64'hFFFF_FFFF_FFFF_FFFF));
        pending_frames.push_back(make_frame(KIND_STD_FLAG, 32'hA5A5_A5A5, 8'h9A, 4'd3,
                                            64'h0123_4567_89AB_CDEF));
        pending_frames.push_back(make_frame(KIND_STD, 32'h0, 8'h5C, 4'd8,
                                            64'hFEDC_BA98_7654_3210));
        pending_frames.push_back(make_frame(KIND_STD_FLAG, 32'h0, 8'hE1, 4'd15,
                                            64'hAAAA_AAAA_AAAA_AAAA));
        pending_frames.push_back(make_frame(KIND_EXT, 32'h0, 8'h00, 4'd0, 64'h0));
        pending_frames.push_back(make_frame(KIND_EXT, 32'hFFFF_FFFF, 8'hFF, 4'd8,
                                            64'hFFFF_FFFF_FFFF_FFFF));
        pending_frames.push_back(make_frame(KIND_EXT, 32'h1234_ABCD, 8'h77, 4'd9,
                                            64'h5555_5555_5555_5555));
        pending_frames.push_back(make_frame(KIND_EXT, 32'h89EF_0A6B, 8'h3C, 4'd15,
                                            64'h0F1E_2D3C_4B5A_6978));
        pending_frames.push_back(make_frame(KIND_UNUSED, 32'hC0DE_F00D, 8'h42, 4'd4,
                                            64'hDEAD_BEEF_CAFE_BABE));
        pending_frames.push_back(make_frame(KIND_UNUSED, 32'h0, 8'hFF, 4'd12,
                                            64'h8080_8080_8080_8080));
        pending_frames.push_back(make_frame(KIND_STD, 32'h0, 8'h0F, 4'd1, 64'hFFFF_FFFF_FFFF_FF00));
        pending_frames.push_back(make_frame(KIND_EXT, 32'h0000_00FF, 8'h00, 4'd1,
                                            64'hFFFF_FFFF_FFFF_FFA5));
        f = make_frame(KIND_STD_FLAG, 32'h0, 8'hF0, 4'd2, 64'h0000_0000_0000_C3B4);
        f.drain_first = 1'b1;
        pending_frames.push_back(f);
        for (int i = 0; i < RANDOM_FRAMES; i++) begin
            f = random_frame();
            f.drain_first = (i == RANDOM_FRAMES / 2);
            pending_frames.push_back(f);
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_frames.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (expected_chars.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
